>>> rtl/fbpa_pkg.sv
// shared types and constants for the fixed block pool allocator
`timescale 1ns / 1ps
`default_nettype none
package fbpa_pkg;
   localparam int MaxBlocks = 1024;
   localparam int IdxBits = $clog2(MaxBlocks);
   localparam int CntBits = IdxBits + 1;
   localparam int AddrBits = 32;
   localparam int StrideBits = 17;
   localparam int OffBits = StrideBits + IdxBits;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_FOREIGN = 3'd2;
   localparam logic [2:0] ST_DOUBLE  = 3'd3;
   localparam logic [2:0] ST_NULL    = 3'd4;

   localparam logic [1:0] REG_BASE   = 2'd0;
   localparam logic [1:0] REG_STRIDE = 2'd1;
   localparam logic [1:0] REG_COUNT  = 2'd2;

   typedef struct packed {
      logic                kind;
      logic [AddrBits-1:0] block_address;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [AddrBits-1:0] granted_address;
      logic [IdxBits-1:0]  granted_index;
      logic [CntBits-1:0]  free_total;
   } rsp_type;

   typedef struct packed {
      logic               done;
      logic               rem_zero;
      logic [IdxBits-1:0] quotient;
   } div_res_type;
endpackage
`default_nettype wire

>>> rtl/fbpa_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

>>> rtl/fbpa_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module fbpa_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [fbpa_pkg::OffBits-1:0]     dividend,
   input  wire logic [fbpa_pkg::StrideBits-1:0]  divisor,
   output fbpa_pkg::div_res_type                 res
);
   localparam int IB = fbpa_pkg::IdxBits;
   localparam int OB = fbpa_pkg::OffBits;
   localparam int SB = fbpa_pkg::StrideBits;

   logic [OB-1:0] rem_ff, rem_in;
   logic [IB-1:0] q_ff, q_in;
   logic [SB-1:0] dvs_ff, dvs_in;
   logic [$clog2(IB)-1:0] cnt_ff, cnt_in;
   logic run_ff, run_in, done_ff, done_in;
   logic [OB-1:0] trial;

   always_comb begin
      trial = {{(OB-SB){1'b0}}, dvs_ff} << cnt_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend;
         q_in = '0;
         dvs_in = divisor;
         cnt_in = ($clog2(IB))'(IB - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            q_in[cnt_ff] = 1'b1;
         end
         if (cnt_ff == '0) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      q_ff <= q_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign res.done = done_ff;
   assign res.rem_zero = (rem_ff == '0);
   assign res.quotient = q_ff;
endmodule
`default_nettype wire

>>> rtl/fixed_block_pool_allocator_unit.sv
// fixed size block pool allocator with a lifo free list
// usage:
//  - a command is taken when start is high and busy is low; req_data.kind
//    selects allocate (0) or release (1) of req_data.block_address
//  - each command gives exactly one result on rsp_data, shown for one cycle
//    with rsp_strobe; the receiver cannot stall, so nothing waits on it
//  - allocate steps through S_AREAD, S_AWAIT and S_AOUT: the free stack read,
//    then the index times stride multiply; an empty pool answers from S_AREAD
//  - release goes through offset and limit, range check, a
//    10-step restoring divide by the stride, then a read and write of the
//    used marks; null and out of range releases finish early
//  - one command is in flight at a time, busy is high until its result
//  - csr writes (csr_valid and csr_ready) set base, stride or block count
//    and reinitialize the pool: all blocks free, highest index first;
//    csr_ready is low while a command is in flight or being started
//  - reset loads base 0, stride 64 and 1024 blocks, pool all free
//  - no clearing pass: entries below the lowest stack top reached since
//    reinit read as their own index and their blocks as free
`timescale 1ns / 1ps
`default_nettype none
module fixed_block_pool_allocator_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire fbpa_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output fbpa_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_data
);
   localparam int IB = fbpa_pkg::IdxBits;
   localparam int CB = fbpa_pkg::CntBits;
   localparam int AB = fbpa_pkg::AddrBits;
   localparam int SB = fbpa_pkg::StrideBits;
   localparam int OB = fbpa_pkg::OffBits;
   localparam int LB = SB + CB;
   localparam logic [CB-1:0] MaxCnt = CB'(fbpa_pkg::MaxBlocks);
   localparam logic [SB-1:0] MinStride = SB'(8);
   localparam logic [SB-1:0] MaxStride = SB'(65536);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_AREAD = 9'b000000010,
      S_AWAIT = 9'b000000100,
      S_AOUT  = 9'b000001000,
      S_RCHK  = 9'b000010000,
      S_RRNG  = 9'b000100000,
      S_RDIV  = 9'b001000000,
      S_RREAD = 9'b010000000,
      S_RWAIT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [AB-1:0] base_ff, base_in;
   logic [SB-1:0] stride_ff, stride_in;
   logic [CB-1:0] count_ff, count_in;
   logic [CB-1:0] top_ff, top_in;
   logic [CB-1:0] mintop_ff, mintop_in;
   fbpa_pkg::req_type req_ff, req_in;
   logic [IB-1:0] idx_ff, idx_in;
   logic [OB-1:0] prod_ff, prod_in;
   logic [AB-1:0] off_ff, off_in;
   logic [LB-1:0] lim_ff, lim_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   fbpa_pkg::rsp_type rsp_ff, rsp_in;

   logic [SB-1:0] eff_stride;
   logic [CB-1:0] eff_count, new_count;
   logic [SB-1:0] raw_stride;
   logic [CB-1:0] raw_count;

   logic stk_we, used_we, used_wdata;
   logic [IB-1:0] stk_raddr, stk_rdata, used_waddr;
   logic used_rdata;
   logic [IB-1:0] pop_idx;
   logic [CB-1:0] top_dec;
   logic div_start;
   fbpa_pkg::div_res_type div_res;
   logic is_used;

   function automatic logic [SB-1:0] clamp_stride(input logic [SB-1:0] s);
      logic [SB-1:0] r;
      r = s;
      if (s < MinStride) r = MinStride;
      else if (s > MaxStride) r = MaxStride;
      return r;
   endfunction

   function automatic logic [CB-1:0] clamp_count(input logic [CB-1:0] c);
      logic [CB-1:0] r;
      r = c;
      if (c == '0) r = CB'(1);
      else if (c > MaxCnt) r = MaxCnt;
      return r;
   endfunction

   assign eff_stride = clamp_stride(stride_ff);
   assign eff_count = clamp_count(count_ff);
   assign raw_stride = csr_data[SB-1:0];
   assign raw_count = csr_data[CB-1:0];
   assign top_dec = top_ff - 1'b1;
   assign stk_raddr = top_dec[IB-1:0];
   // never written below the lowest top since reinit: holds its own index
   assign pop_idx = (top_dec < mintop_ff) ? top_dec[IB-1:0] : stk_rdata;
   assign is_used = ({1'b0, idx_ff} >= mintop_ff) && used_rdata;

   always_comb begin
      state_in = state_ff;
      base_in = base_ff;
      stride_in = stride_ff;
      count_in = count_ff;
      top_in = top_ff;
      mintop_in = mintop_ff;
      req_in = req_ff;
      idx_in = idx_ff;
      prod_in = prod_ff;
      off_in = off_ff;
      lim_in = lim_ff;
      rsp_strobe_in = 1'b0;
      rsp_in = rsp_ff;
      stk_we = 1'b0;
      used_we = 1'b0;
      used_waddr = idx_ff;
      used_wdata = 1'b0;
      div_start = 1'b0;
      new_count = eff_count;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               state_in = req_data.kind ? S_RCHK : S_AREAD;
            end else if (csr_valid) begin
               case (csr_index)
                  fbpa_pkg::REG_BASE: begin
                     base_in = csr_data;
                  end
                  fbpa_pkg::REG_STRIDE: begin
                     stride_in = raw_stride;
                  end
                  fbpa_pkg::REG_COUNT: begin
                     count_in = raw_count;
                     new_count = clamp_count(raw_count);
                  end
                  default: begin
                  end
               endcase
               if (csr_index != 2'd3) begin
                  top_in = new_count;
                  mintop_in = new_count;
               end
            end
         end
         S_AREAD: begin
            if (top_ff == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_in = '{status: fbpa_pkg::ST_EMPTY, granted_address: '0,
                          granted_index: '0, free_total: top_ff};
               state_in = S_IDLE;
            end else begin
               state_in = S_AWAIT;
            end
         end
         S_AWAIT: begin
            idx_in = pop_idx;
            prod_in = {{(OB-IB){1'b0}}, pop_idx} * {{(OB-SB){1'b0}}, eff_stride};
            used_we = 1'b1;
            used_waddr = pop_idx;
            used_wdata = 1'b1;
            top_in = top_dec;
            if (top_dec < mintop_ff) mintop_in = top_dec;
            state_in = S_AOUT;
         end
         S_AOUT: begin
            rsp_strobe_in = 1'b1;
            rsp_in = '{status: fbpa_pkg::ST_OK,
                       granted_address: base_ff + AB'(prod_ff),
                       granted_index: idx_ff, free_total: top_ff};
            state_in = S_IDLE;
         end
         S_RCHK: begin
            if (req_ff.block_address == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_in = '{status: fbpa_pkg::ST_NULL, granted_address: '0,
                          granted_index: '0, free_total: top_ff};
               state_in = S_IDLE;
            end else begin
               off_in = req_ff.block_address - base_ff;
               lim_in = {{(LB-SB){1'b0}}, eff_stride} * {{(LB-CB){1'b0}}, eff_count};
               state_in = S_RRNG;
            end
         end
         S_RRNG: begin
            if (off_ff >= AB'(lim_ff)) begin
               rsp_strobe_in = 1'b1;
               rsp_in = '{status: fbpa_pkg::ST_FOREIGN, granted_address: '0,
                          granted_index: '0, free_total: top_ff};
               state_in = S_IDLE;
            end else begin
               div_start = 1'b1;
               state_in = S_RDIV;
            end
         end
         S_RDIV: begin
            if (div_res.done) begin
               if (!div_res.rem_zero) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = '{status: fbpa_pkg::ST_FOREIGN, granted_address: '0,
                             granted_index: '0, free_total: top_ff};
                  state_in = S_IDLE;
               end else begin
                  idx_in = div_res.quotient;
                  state_in = S_RREAD;
               end
            end
         end
         S_RREAD: begin
            state_in = S_RWAIT;
         end
         S_RWAIT: begin
            rsp_strobe_in = 1'b1;
            if (!is_used || top_ff >= MaxCnt) begin
               rsp_in = '{status: fbpa_pkg::ST_DOUBLE, granted_address: '0,
                          granted_index: '0, free_total: top_ff};
            end else begin
               used_we = 1'b1;
               stk_we = 1'b1;
               top_in = top_ff + 1'b1;
               rsp_in = '{status: fbpa_pkg::ST_OK, granted_address: '0,
                          granted_index: idx_ff, free_total: top_ff + 1'b1};
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         base_ff <= '0;
         stride_ff <= SB'(64);
         count_ff <= MaxCnt;
         top_ff <= MaxCnt;
         mintop_ff <= MaxCnt;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in;
         stride_ff <= stride_in;
         count_ff <= count_in;
         top_ff <= top_in;
         mintop_ff <= mintop_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff <= req_in;
      idx_ff <= idx_in;
      prod_ff <= prod_in;
      off_ff <= off_in;
      lim_ff <= lim_in;
      rsp_ff <= rsp_in;
   end

   fbpa_ram #(.WIDTH(IB), .DEPTH(fbpa_pkg::MaxBlocks)) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (top_ff[IB-1:0]),
      .wdata (idx_ff),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   fbpa_ram #(.WIDTH(1), .DEPTH(fbpa_pkg::MaxBlocks)) u_used (
      .clock (clock),
      .we    (used_we),
      .waddr (used_waddr),
      .wdata (used_wdata),
      .raddr (idx_ff),
      .rdata (used_rdata)
   );

   fbpa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (off_ff[OB-1:0]),
      .divisor  (eff_stride),
      .res      (div_res)
   );

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

>>> sim/testbench.sv
// self-checking testbench for the fixed block pool allocator unit
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   localparam int WatchLimit = 20000;
   localparam int MaxBlocks = fbpa_pkg::MaxBlocks;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   fbpa_pkg::req_type req_data = '0;
   logic rsp_strobe;
   fbpa_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   fixed_block_pool_allocator_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // pool model
   logic [31:0] pool_base;
   logic [16:0] pool_stride;
   logic [10:0] pool_count;
   logic [9:0] free_stack [MaxBlocks];
   logic [10:0] free_top;
   logic in_use [MaxBlocks];

   fbpa_pkg::req_type cmd_queue[$];
   fbpa_pkg::rsp_type grant_queue[$];
   int idle_pct = 0;
   bit hold = 1'b0;
   int errors = 0;
   int watch = 0;
   int n_rsp = 0;
   int n_status [5] = '{default: 0};
   bit csr_pending = 1'b0;
   logic [1:0] csr_idx_next;
   logic [31:0] csr_data_next;

   function automatic logic [31:0] eff_stride();
      if (pool_stride < 8) return 8;
      if (pool_stride > 17'd65536) return 65536;
      return 32'(pool_stride);
   endfunction

   function automatic logic [10:0] eff_count();
      if (pool_count == 0) return 11'd1;
      if (pool_count > MaxBlocks) return 11'(MaxBlocks);
      return pool_count;
   endfunction

   function automatic void pool_reinit();
      for (int k = 0; k < MaxBlocks; k++) begin
         free_stack[k] = 10'(k);
         in_use[k] = 1'b0;
      end
      free_top = eff_count();
   endfunction

   function automatic fbpa_pkg::rsp_type pool_step(fbpa_pkg::req_type r);
      fbpa_pkg::rsp_type o;
      logic [63:0] off, lim, strd;
      logic [9:0] idx;
      o = '0;
      strd = 64'(eff_stride());
      if (!r.kind) begin
         if (free_top == 0) o.status = fbpa_pkg::ST_EMPTY;
         else begin
            free_top--;
            idx = free_stack[free_top];
            in_use[idx] = 1'b1;
            o.granted_index = idx;
            o.granted_address = pool_base + 32'(idx) * strd[31:0];
         end
      end else if (r.block_address == 0) begin
         o.status = fbpa_pkg::ST_NULL;
      end else begin
         off = {32'd0, r.block_address - pool_base};
         lim = strd * 64'(eff_count());
         if (off >= lim || (off % strd) != 0) o.status = fbpa_pkg::ST_FOREIGN;
         else begin
            idx = 10'(off / strd);
            if (!in_use[idx] || free_top >= MaxBlocks) o.status = fbpa_pkg::ST_DOUBLE;
            else begin
               in_use[idx] = 1'b0;
               free_stack[free_top] = idx;
               free_top++;
               o.granted_index = idx;
            end
         end
      end
      o.free_total = free_top;
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (csr_valid && csr_ready) csr_valid <= 1'b0;
      if (!reset && csr_pending && !csr_valid) begin
         csr_valid <= 1'b1;
         csr_index <= csr_idx_next;
         csr_data <= csr_data_next;
         csr_pending = 1'b0;
      end
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (cmd_queue.size() > 0 && !hold && $urandom_range(99) >= idle_pct) begin
            req_data <= cmd_queue[0];
            grant_queue.push_back(pool_step(cmd_queue.pop_front()));
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) watch <= 0;
         else watch <= watch + 1;
         if (rsp_strobe) begin
            n_rsp++;
            if (grant_queue.size() == 0) begin
               $error("unexpected result status=%0d", rsp_data.status);
               errors++;
            end else begin
               fbpa_pkg::rsp_type e;
               e = grant_queue.pop_front();
               if (rsp_data.status <= fbpa_pkg::ST_NULL) n_status[rsp_data.status]++;
               if (e.status !== rsp_data.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_data.status);
                  errors++;
               end
               if (e.granted_address !== rsp_data.granted_address) begin
                  $error("granted_address exp %h got %h", e.granted_address,
                     rsp_data.granted_address);
                  errors++;
               end
               if (e.granted_index !== rsp_data.granted_index) begin
                  $error("granted_index exp %0d got %0d", e.granted_index,
                     rsp_data.granted_index);
                  errors++;
               end
               if (e.free_total !== rsp_data.free_total) begin
                  $error("free_total exp %0d got %0d", e.free_total,
                     rsp_data.free_total);
                  errors++;
               end
            end
         end
         if (watch >= WatchLimit) begin
            $display("watchdog expired");
            $display("[fixed_block_pool_allocator_unit] ERROR");
            $finish;
         end
      end
   end

   task automatic drain();
      while (cmd_queue.size() > 0 || grant_queue.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      drain();
      csr_idx_next = idx;
      csr_data_next = val;
      csr_pending = 1'b1;
      @(posedge clock);
      while (csr_pending || csr_valid) @(posedge clock);
      case (idx)
         fbpa_pkg::REG_BASE: pool_base = val;
         fbpa_pkg::REG_STRIDE: pool_stride = val[16:0];
         default: pool_count = val[10:0];
      endcase
      pool_reinit();
   endtask

   function automatic logic [31:0] addr_of(int idx);
      return pool_base + 32'(idx) * eff_stride();
   endfunction

   task automatic push_cmd(bit kind, logic [31:0] a);
      fbpa_pkg::req_type r;
      r.kind = kind;
      r.block_address = a;
      cmd_queue.push_back(r);
   endtask

   // mixed random traffic of allocates and releases; releases mostly target
   // aligned addresses of blocks in the pool, whether granted or not
   task automatic random_phase(int n);
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 45) begin
            push_cmd(1'b0, $urandom);
         end else if (sel < 85) begin
            push_cmd(1'b1, addr_of($urandom_range(eff_count() - 1)));
         end else if (sel < 90) begin
            push_cmd(1'b1, 32'd0);
         end else if (sel < 95) begin
            push_cmd(1'b1, addr_of($urandom_range(eff_count() - 1))
               + $urandom_range(1, 7));
         end else begin
            push_cmd(1'b1, $urandom);
         end
      end
   endtask

   initial begin
      pool_base = 0;
      pool_stride = 64;
      pool_count = 1024;
      pool_reinit();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: small pool, empty, double free, null, foreign, extremes
      write_reg(fbpa_pkg::REG_COUNT, 3);
      write_reg(fbpa_pkg::REG_BASE, 32'hFFFF_FFC0);
      write_reg(fbpa_pkg::REG_STRIDE, 8);
      for (int i = 0; i < 4; i++) push_cmd(1'b0, 32'hFFFF_FFFF);
      push_cmd(1'b1, 32'hFFFF_FFC8);
      push_cmd(1'b1, 32'hFFFF_FFC8);
      push_cmd(1'b1, 32'd0);
      push_cmd(1'b1, 32'hFFFF_FFC4);
      push_cmd(1'b1, 32'hFFFF_FFD8);
      push_cmd(1'b1, 32'hFFFF_FFC0);
      push_cmd(1'b0, 32'd0);
      write_reg(fbpa_pkg::REG_STRIDE, 0);
      write_reg(fbpa_pkg::REG_COUNT, 0);
      push_cmd(1'b0, 32'd0);
      push_cmd(1'b0, 32'd0);
      push_cmd(1'b1, 32'hFFFF_FFC0);
      push_cmd(1'b1, 32'h8000_0000);
      write_reg(fbpa_pkg::REG_STRIDE, 32'h1FFFF);
      write_reg(fbpa_pkg::REG_COUNT, 32'h7FF);
      write_reg(fbpa_pkg::REG_BASE, 32'h0);
      push_cmd(1'b0, 32'd0);
      push_cmd(1'b1, 32'd0);
      push_cmd(1'b1, 32'h03FF_0000);
      push_cmd(1'b0, 32'd0);

      // random phases
      idle_pct = 36;
      write_reg(fbpa_pkg::REG_STRIDE, 64);
      write_reg(fbpa_pkg::REG_COUNT, 16);
      random_phase(300);
      drain();
      hold = 1'b1;
      repeat (5) @(posedge clock);
      hold = 1'b0;
      idle_pct = 85;
      write_reg(fbpa_pkg::REG_BASE, $urandom);
      write_reg(fbpa_pkg::REG_STRIDE, $urandom_range(8, 65536));
      write_reg(fbpa_pkg::REG_COUNT, $urandom_range(1, 40));
      random_phase(300);
      idle_pct = 0;
      write_reg(fbpa_pkg::REG_STRIDE, 65536);
      write_reg(fbpa_pkg::REG_COUNT, 1024);
      write_reg(fbpa_pkg::REG_BASE, 32'hFFF0_0000);
      for (int i = 0; i < 200; i++) push_cmd(1'b0, $urandom);
      random_phase(300);
      drain();

      $display("results %0d: ok %0d empty %0d foreign %0d double %0d null %0d",
         n_rsp, n_status[0], n_status[1], n_status[2], n_status[3], n_status[4]);
      $display("register extremes, pool exhaustion and wrap of the region covered");
      if (errors == 0) begin
         $display("[fixed_block_pool_allocator_unit] OK");
      end else begin
         $display("[fixed_block_pool_allocator_unit] ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
